>>> rtl/core/rc5_pkg.sv
// Shared types, constants and rotate helpers for the RC5 CBC cipher core.
// No dependencies; every other file in rtl/core imports this package.
package rc5_pkg;

  localparam int WORD_W        = 32;
  localparam int BLOCK_W       = 64;
  localparam int CFG_IDX_W     = 2;
  localparam int ROUNDS_DEF    = 12;
  localparam int KEY_BYTES_DEF = 16;

  // Magic constants of the RC5 key schedule for 32-bit words.
  localparam logic [WORD_W-1:0] MAGIC_P = 32'hB7E1_5163;
  localparam logic [WORD_W-1:0] MAGIC_Q = 32'h9E37_79B9;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_VECTOR = 2'd2;

  typedef struct packed {
    logic [BLOCK_W-1:0] key_low;
    logic [BLOCK_W-1:0] key_high;
    logic [BLOCK_W-1:0] init_vector;
  } cfg_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                             input logic [4:0]        s);
    logic [2*WORD_W-1:0] d;
    d = {x, x} << s;
    return d[2*WORD_W-1:WORD_W];
  endfunction

  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                             input logic [4:0]        s);
    logic [2*WORD_W-1:0] d;
    d = {x, x} >> s;
    return d[WORD_W-1:0];
  endfunction

endpackage

>>> rtl/core/rc5_ram.sv
// Round-key table: one write port and one read port with registered read data.
// Depends on rc5_pkg for the word width.
module rc5_ram
  import rc5_pkg::*;
#(
  parameter int DEPTH = 2 * ROUNDS_DEF + 2,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/rc5_engine.sv
// Sequencer and datapath: key schedule, half-round unit, CBC chaining and
// the output register. Drives the round-key RAM. Depends on rc5_pkg.
module rc5_engine
  import rc5_pkg::*;
#(
  parameter int ROUNDS    = ROUNDS_DEF,
  parameter int KEY_BYTES = KEY_BYTES_DEF,
  localparam int TW       = 2 * ROUNDS + 2,
  localparam int AW       = $clog2(TW)
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic               first,
  input  logic [BLOCK_W-1:0] data_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [BLOCK_W-1:0] data_out,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output logic [WORD_W-1:0]  ram_wdata,
  output logic [AW-1:0]      ram_raddr,
  input  logic [WORD_W-1:0]  ram_rdata
);

  localparam int KW     = (KEY_BYTES + 3) / 4;
  localparam int JW     = (KW > 1) ? $clog2(KW) : 1;
  localparam int NSTEPS = 3 * TW;
  localparam int NW     = $clog2(NSTEPS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_KEY,
    S_PRIME,
    S_CIPHER,
    S_DONE
  } state_t;

  state_t             state;
  logic               phase;
  logic [NW-1:0]      n;
  logic [AW-1:0]      i;
  logic [JW-1:0]      j;
  logic [WORD_W-1:0]  init_val;
  logic [WORD_W-1:0]  ka;
  logic [WORD_W-1:0]  kb;
  logic [WORD_W-1:0]  lw [KW];
  logic [AW-1:0]      idx;
  logic               is_dec;
  logic [WORD_W-1:0]  ca;
  logic [WORD_W-1:0]  cb;
  logic [BLOCK_W-1:0] din;
  logic [BLOCK_W-1:0] chain;

  logic [WORD_W-1:0]  key_words [KW];
  logic [AW-1:0]      i_inc;
  logic [JW-1:0]      j_inc;
  logic [WORD_W-1:0]  s_old;
  logic [WORD_W-1:0]  key_a;
  logic [WORD_W-1:0]  key_sum;
  logic [WORD_W-1:0]  key_b;
  logic [WORD_W-1:0]  a_next;
  logic [WORD_W-1:0]  b_next;
  logic               last_step;
  logic [AW-1:0]      idx_adv;
  logic [BLOCK_W-1:0] start_chain;
  logic [BLOCK_W-1:0] start_blk;
  logic               accept;
  logic               out_free;

  // Only the first KEY_BYTES bytes of the key take part; the rest read as zero.
  always_comb begin
    logic [2*BLOCK_W-1:0] key_all;
    key_all = {cfg.key_high, cfg.key_low};
    for (int w = 0; w < KW; w++) begin
      for (int b = 0; b < 4; b++) begin
        if (4 * w + b < KEY_BYTES) begin
          key_words[w][8*b +: 8] = key_all[8*(4*w+b) +: 8];
        end else begin
          key_words[w][8*b +: 8] = 8'h00;
        end
      end
    end
  end

  assign i_inc = (i == AW'(TW - 1)) ? '0 : i + 1'b1;
  assign j_inc = (j == JW'(KW - 1)) ? '0 : j + 1'b1;

  // During the first pass the table still holds its initial pattern, which is
  // generated here instead of being swept into the RAM beforehand.
  assign s_old   = (n < NW'(TW)) ? init_val : ram_rdata;
  assign key_a   = rotl(s_old + ka + kb, 5'd3);
  assign key_sum = ka + kb;
  assign key_b   = rotl(lw[j] + key_sum, key_sum[4:0]);

  // One half-round per cycle; the round key comes straight from the RAM.
  always_comb begin
    a_next = ca;
    b_next = cb;
    if (!is_dec) begin
      if (idx == '0) begin
        a_next = ca + ram_rdata;
      end else if (idx == AW'(1)) begin
        b_next = cb + ram_rdata;
      end else if (!idx[0]) begin
        a_next = rotl(ca ^ cb, cb[4:0]) + ram_rdata;
      end else begin
        b_next = rotl(cb ^ ca, ca[4:0]) + ram_rdata;
      end
    end else begin
      if (idx == '0) begin
        a_next = ca - ram_rdata;
      end else if (idx == AW'(1)) begin
        b_next = cb - ram_rdata;
      end else if (!idx[0]) begin
        a_next = rotr(ca - ram_rdata, cb[4:0]) ^ cb;
      end else begin
        b_next = rotr(cb - ram_rdata, ca[4:0]) ^ ca;
      end
    end
  end

  assign last_step = is_dec ? (idx == '0) : (idx == AW'(TW - 1));
  assign idx_adv   = is_dec ? idx - 1'b1 : idx + 1'b1;

  always_comb begin
    case (state)
      S_KEY:    ram_raddr = i_inc;
      S_CIPHER: ram_raddr = last_step ? idx : idx_adv;
      default:  ram_raddr = idx;
    endcase
  end

  assign ram_we    = (state == S_KEY) && !phase;
  assign ram_waddr = i;
  assign ram_wdata = key_a;

  assign in_stall    = (state != S_IDLE);
  assign accept      = in_valid && !in_stall;
  assign out_free    = !out_valid || !out_stall;
  assign start_chain = first ? cfg.init_vector : chain;
  assign start_blk   = action ? data_in : data_in ^ start_chain;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= 1'b0;
      out_valid <= 1'b0;
      chain     <= '0;
    end else begin
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            is_dec <= action;
            din    <= data_in;
            chain  <= start_chain;
            ca     <= start_blk[WORD_W-1:0];
            cb     <= start_blk[BLOCK_W-1:WORD_W];
            idx    <= action ? AW'(TW - 1) : '0;
            if (first) begin
              ka       <= '0;
              kb       <= '0;
              i        <= '0;
              j        <= '0;
              n        <= '0;
              phase    <= 1'b0;
              init_val <= MAGIC_P;
              for (int w = 0; w < KW; w++) begin
                lw[w] <= key_words[w];
              end
              state <= S_KEY;
            end else begin
              state <= S_PRIME;
            end
          end
        end
        S_KEY: begin
          if (!phase) begin
            ka    <= key_a;
            phase <= 1'b1;
          end else begin
            kb       <= key_b;
            lw[j]    <= key_b;
            i        <= i_inc;
            j        <= j_inc;
            init_val <= init_val + MAGIC_Q;
            n        <= n + 1'b1;
            phase    <= 1'b0;
            if (n == NW'(NSTEPS - 1)) begin
              state <= S_PRIME;
            end
          end
        end
        S_PRIME: begin
          state <= S_CIPHER;
        end
        S_CIPHER: begin
          ca <= a_next;
          cb <= b_next;
          if (last_step) begin
            state <= S_DONE;
          end else begin
            idx <= idx_adv;
          end
        end
        S_DONE: begin
          if (out_free) begin
            data_out <= is_dec ? ({cb, ca} ^ chain) : {cb, ca};
            chain    <= is_dec ? din : {cb, ca};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/rc5_cbc_block_cipher_core.sv
// Top level of the RC5-32 CBC cipher: configuration registers, round-key RAM
// and the engine. Depends on rc5_pkg, rc5_ram and rc5_engine.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+-------------------------
//   config   | cfg_write                    | cfg_index, cfg_data
//   input    | in_valid / in_stall (driven) | action, first, data_in
//   output   | out_valid / out_stall        | data_out
//
// The single RAM read port feeds one half-round per cycle over 2*ROUNDS+2
// keys. An item marked first runs the key schedule first, over 3*(2*ROUNDS+2)
// mixing steps. Reset is synchronous and clears control state, the chaining
// value and the configuration registers. A result waiting in the output
// register does not keep the next item from being accepted.
module rc5_cbc_block_cipher_core
  import rc5_pkg::*;
#(
  parameter int ROUNDS    = ROUNDS_DEF,
  parameter int KEY_BYTES = KEY_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BLOCK_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 action,
  input  logic                 first,
  input  logic [BLOCK_W-1:0]   data_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BLOCK_W-1:0]   data_out
);

  localparam int TW = 2 * ROUNDS + 2;
  localparam int AW = $clog2(TW);

  cfg_t              cfg;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_KEY_LOW:     cfg.key_low     <= cfg_data;
        CFG_KEY_HIGH:    cfg.key_high    <= cfg_data;
        CFG_INIT_VECTOR: cfg.init_vector <= cfg_data;
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  rc5_ram #(
    .DEPTH (TW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rc5_engine #(
    .ROUNDS    (ROUNDS),
    .KEY_BYTES (KEY_BYTES)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .first     (first),
    .data_in   (data_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data_out  (data_out),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for rc5_cbc_block_cipher_core (RC5-32/12/16 in CBC mode).
// A behavioral cipher model in this file predicts every block; needs rc5_pkg and the core RTL.
module tb;
  import rc5_pkg::*;

  localparam int TABLE_WORDS     = 2 * ROUNDS_DEF + 2;
  localparam int KEY_WORDS       = (KEY_BYTES_DEF + 3) / 4;
  localparam int BLOCK_CYCLES    = 2 * ROUNDS_DEF + 5;
  localparam int SCHEDULE_CYCLES = 6 * TABLE_WORDS;
  localparam int CYCLE_LIMIT     = 2_000_000;

  localparam logic ACT_ENCRYPT = 1'b0;
  localparam logic ACT_DECRYPT = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BLOCK_W-1:0]   cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 action;
  logic                 first;
  logic [BLOCK_W-1:0]   data_in;
  logic                 out_valid;
  logic                 out_stall;
  logic [BLOCK_W-1:0]   data_out;

  rc5_cbc_block_cipher_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .first     (first),
    .data_in   (data_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data_out  (data_out)
  );

  always #1 clk = ~clk;

  // Cipher model state: register copies, round-key table and chaining value.
  logic [BLOCK_W-1:0] model_key_low;
  logic [BLOCK_W-1:0] model_key_high;
  logic [BLOCK_W-1:0] model_iv;
  logic [BLOCK_W-1:0] model_chain;
  logic [WORD_W-1:0]  sched [TABLE_WORDS];

  logic [BLOCK_W-1:0] expected_blocks [$];
  logic [BLOCK_W-1:0] want_block;
  int errors;
  int items_sent;
  int blocks_checked;
  int messages;
  int reg_writes;
  int cycle_count;
  int tx_idle_pct;
  int rx_idle_pct;

  function automatic logic [WORD_W-1:0] rol32(logic [WORD_W-1:0] x, logic [WORD_W-1:0] amt);
    int s;
    s = int'(amt[4:0]);
    if (s == 0) return x;
    return (x << s) | (x >> (WORD_W - s));
  endfunction

  function automatic logic [WORD_W-1:0] ror32(logic [WORD_W-1:0] x, logic [WORD_W-1:0] amt);
    int s;
    s = int'(amt[4:0]);
    if (s == 0) return x;
    return (x >> s) | (x << (WORD_W - s));
  endfunction

  function automatic void expand_schedule();
    logic [WORD_W-1:0]    lw [KEY_WORDS];
    logic [2*BLOCK_W-1:0] key;
    logic [WORD_W-1:0]    a;
    logic [WORD_W-1:0]    b;
    int i;
    int j;
    int steps;
    key = {model_key_high, model_key_low};
    for (i = 0; i < KEY_WORDS; i++) lw[i] = '0;
    for (i = KEY_BYTES_DEF - 1; i >= 0; i--) lw[i / 4] = (lw[i / 4] << 8) | key[8*i +: 8];
    sched[0] = MAGIC_P;
    for (i = 1; i < TABLE_WORDS; i++) sched[i] = sched[i-1] + MAGIC_Q;
    steps = 3 * ((TABLE_WORDS > KEY_WORDS) ? TABLE_WORDS : KEY_WORDS);
    a = '0;
    b = '0;
    i = 0;
    j = 0;
    for (int n = 0; n < steps; n++) begin
      sched[i] = rol32(sched[i] + a + b, 3);
      a = sched[i];
      lw[j] = rol32(lw[j] + a + b, a + b);
      b = lw[j];
      i = (i + 1) % TABLE_WORDS;
      j = (j + 1) % KEY_WORDS;
    end
  endfunction

  function automatic logic [BLOCK_W-1:0] rc5_encrypt(logic [BLOCK_W-1:0] blk);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    a = blk[WORD_W-1:0] + sched[0];
    b = blk[BLOCK_W-1:WORD_W] + sched[1];
    for (int r = 1; r <= ROUNDS_DEF; r++) begin
      a = rol32(a ^ b, b) + sched[2*r];
      b = rol32(b ^ a, a) + sched[2*r+1];
    end
    return {b, a};
  endfunction

  function automatic logic [BLOCK_W-1:0] rc5_decrypt(logic [BLOCK_W-1:0] blk);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    a = blk[WORD_W-1:0];
    b = blk[BLOCK_W-1:WORD_W];
    for (int r = ROUNDS_DEF; r >= 1; r--) begin
      b = ror32(b - sched[2*r+1], a) ^ a;
      a = ror32(a - sched[2*r], b) ^ b;
    end
    b = b - sched[1];
    a = a - sched[0];
    return {b, a};
  endfunction

  // One CBC step: a message start reloads the schedule and the chaining value.
  function automatic logic [BLOCK_W-1:0] cbc_cipher_step(logic act, logic start,
                                                         logic [BLOCK_W-1:0] blk);
    logic [BLOCK_W-1:0] res;
    if (start) begin
      expand_schedule();
      model_chain = model_iv;
    end
    if (act == ACT_ENCRYPT) begin
      res = rc5_encrypt(blk ^ model_chain);
      model_chain = res;
    end else begin
      res = rc5_decrypt(blk) ^ model_chain;
      model_chain = blk;
    end
    return res;
  endfunction

  function automatic logic [BLOCK_W-1:0] rand_block();
    logic [BLOCK_W-1:0] one_hot;
    one_hot = 64'd1 << $urandom_range(0, BLOCK_W - 1);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return one_hot;
      3: return ~one_hot;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // All tasks below start and end just after a falling edge.
  task automatic send_block(input logic act, input logic start, input logic [BLOCK_W-1:0] blk,
                            output logic [BLOCK_W-1:0] predicted);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < tx_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    first    <= start;
    data_in  <= blk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = cbc_cipher_step(act, start, blk);
    expected_blocks.push_back(predicted);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_blocks.size() != 0) @(negedge clk);
  endtask

  // Only called while no item is in flight.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BLOCK_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
    case (idx)
      CFG_KEY_LOW:     model_key_low = val;
      CFG_KEY_HIGH:    model_key_high = val;
      CFG_INIT_VECTOR: model_iv = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic test_directed();
    logic [BLOCK_W-1:0] ct [4];
    logic [BLOCK_W-1:0] res;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // All-zero key and IV: the first block is the plain RC5 known-answer case.
    write_reg(CFG_KEY_LOW, '0);
    write_reg(CFG_KEY_HIGH, '0);
    write_reg(CFG_INIT_VECTOR, '0);
    send_block(ACT_ENCRYPT, 1'b1, '0, ct[0]);
    send_block(ACT_ENCRYPT, 1'b0, '1, ct[1]);
    send_block(ACT_ENCRYPT, 1'b0, 64'h1, ct[2]);
    send_block(ACT_ENCRYPT, 1'b0, 64'h8000_0000_0000_0000, ct[3]);
    for (int k = 0; k < 4; k++) send_block(ACT_DECRYPT, k == 0, ct[k], res);
    wait_idle();

    write_reg(CFG_KEY_LOW, '1);
    write_reg(CFG_KEY_HIGH, '1);
    write_reg(CFG_INIT_VECTOR, '1);
    send_block(ACT_DECRYPT, 1'b1, '1, res);
    send_block(ACT_DECRYPT, 1'b0, '0, res);
    send_block(ACT_ENCRYPT, 1'b0, '1, res);
    send_block(ACT_ENCRYPT, 1'b0, '0, res);
    wait_idle();

    // A write to the spare index comes first; every register is then rewritten.
    write_reg(CFG_UNUSED, {$urandom, $urandom});
    write_reg(CFG_KEY_LOW, 64'h0706_0504_0302_0100);
    write_reg(CFG_KEY_HIGH, 64'h0F0E_0D0C_0B0A_0908);
    write_reg(CFG_INIT_VECTOR, {$urandom, $urandom});
    send_block(ACT_ENCRYPT, 1'b1, {$urandom, $urandom}, res);
    send_block(ACT_ENCRYPT, 1'b0, {$urandom, $urandom}, res);
    send_block(ACT_ENCRYPT, 1'b1, {$urandom, $urandom}, res);
    send_block(ACT_DECRYPT, 1'b0, {$urandom, $urandom}, res);
    wait_idle();

    // A key change takes effect only at the next message start.
    write_reg(CFG_KEY_HIGH, {$urandom, $urandom});
    send_block(ACT_ENCRYPT, 1'b0, {$urandom, $urandom}, res);
    send_block(ACT_DECRYPT, 1'b0, {$urandom, $urandom}, res);
    send_block(ACT_DECRYPT, 1'b1, {$urandom, $urandom}, res);
    wait_idle();
  endtask

  task automatic test_random_messages(input int target, input int tx_pct, input int rx_pct);
    logic [BLOCK_W-1:0]   plain [$];
    logic [BLOCK_W-1:0]   cipher [$];
    logic [BLOCK_W-1:0]   res;
    logic [CFG_IDX_W-1:0] idx;
    int start_count;
    int len;
    int kind;
    int k;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start_count = items_sent;
    while (items_sent - start_count < target) begin
      if ($urandom_range(0, 3) == 0) begin
        wait_idle();
        repeat ($urandom_range(1, 3)) begin
          idx = CFG_IDX_W'($urandom_range(0, 3));
          write_reg(idx, rand_block());
        end
      end
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
      kind = $urandom_range(0, 9);
      plain.delete();
      cipher.delete();
      for (k = 0; k < len; k++) plain.push_back(rand_block());
      if (kind <= 3) begin
        for (k = 0; k < len; k++) send_block(ACT_ENCRYPT, k == 0, plain[k], res);
      end else if (kind <= 5) begin
        for (k = 0; k < len; k++) send_block(ACT_DECRYPT, k == 0, plain[k], res);
      end else if (kind <= 8) begin
        // Encrypt a message, then restart and decrypt its ciphertext.
        for (k = 0; k < len; k++) begin
          send_block(ACT_ENCRYPT, k == 0, plain[k], res);
          cipher.push_back(res);
        end
        for (k = 0; k < len; k++) send_block(ACT_DECRYPT, k == 0, cipher[k], res);
      end else begin
        for (k = 0; k < len; k++)
          send_block(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0, plain[k], res);
      end
      messages++;
    end
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < rx_idle_pct);

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_blocks.size() == 0) begin
        $display("%0t: unexpected result, expected none, got data_out=%016h", $time, data_out);
        errors++;
      end else begin
        want_block = expected_blocks.pop_front();
        if (data_out !== want_block) begin
          $display("%0t: data_out mismatch, expected %016h, got %016h",
                   $time, want_block, data_out);
          errors++;
        end
        blocks_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_blocks.size());
      $display("FAIL rc5_cbc_block_cipher_core");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_index      = CFG_KEY_LOW;
    cfg_data       = '0;
    in_valid       = 1'b0;
    action         = ACT_ENCRYPT;
    first          = 1'b0;
    data_in        = '0;
    out_stall      = 1'b0;
    model_key_low  = '0;
    model_key_high = '0;
    model_iv       = '0;
    model_chain    = '0;
    for (int i = 0; i < TABLE_WORDS; i++) sched[i] = '0;
    errors         = 0;
    items_sent     = 0;
    blocks_checked = 0;
    messages       = 0;
    reg_writes     = 0;
    cycle_count    = 0;
    tx_idle_pct    = 0;
    rx_idle_pct    = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_random_messages(570, 28, 83);
    test_random_messages(570, 83, 28);
    test_random_messages(570, 0, 0);
    wait_idle();
    repeat (BLOCK_CYCLES + SCHEDULE_CYCLES) @(posedge clk);

    $display("Sent %0d blocks in %0d random messages plus directed cases; %0d results checked.",
             items_sent, messages, blocks_checked);
    $display("Made %0d register writes, including the spare index, under three idling patterns.",
             reg_writes);
    if (errors == 0) begin
      $display("PASS rc5_cbc_block_cipher_core");
    end else begin
      $display("FAIL rc5_cbc_block_cipher_core");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/rc5_pkg.sv
rtl/core/rc5_ram.sv
rtl/core/rc5_engine.sv
rtl/core/rc5_cbc_block_cipher_core.sv
sim/tb.sv
